[hw/rtl/gst_pkg.sv]
// ----------------------------------------------------------------------------
// gst_pkg: shared types and constants of the generational slot table
// Field widths, operation and status codes, and the sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none

package gst_pkg;

	localparam int SLOTS = 256;
	localparam int IDX_W = 8;
	localparam int CNT_W = 9;
	localparam int VER_W = 16;
	localparam int PAY_W = 32;

	localparam logic [CNT_W-1:0] SLOT_CNT = CNT_W'(SLOTS);

	typedef enum logic [1:0] {
		KIND_INSERT  = 2'd0,
		KIND_GET     = 2'd1,
		KIND_REMOVE  = 2'd2,
		KIND_COMPACT = 2'd3
	} gst_kind_t;

	typedef enum logic [1:0] {
		STATUS_OK      = 2'd0,
		STATUS_INVALID = 2'd1,
		STATUS_FULL    = 2'd2
	} gst_status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_GET_CHK,
		S_REM_CHK,
		S_INS_POP,
		S_INS_VER,
		S_CP_RD,
		S_CP_CHK,
		S_CP_SRCH,
		S_CP_SWRD,
		S_CP_SWWR,
		S_FIN
	} gst_state_t;

endpackage

`default_nettype wire

[hw/rtl/gst_ram.sv]
// ----------------------------------------------------------------------------
// gst_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module gst_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire logic                                          clk,
	input  wire logic                                          we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                              wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                              rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

[hw/rtl/generational_slot_table_unit.sv]
// ----------------------------------------------------------------------------
// generational_slot_table_unit: handle table with per-slot version counts
// Operations: insert of a new slot, get, remove, and insert that reuses a
// freed slot. Compact ends on an empty table or stops at a live slot; per
// trimmed slot it runs a linear free-stack search and unlink (one stack
// RAM read per cycle).
// One item at a time: the next item is accepted the cycle after the result
// is registered. Reset clears counts and control; the RAMs are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module generational_slot_table_unit (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	// request channel
	input  wire logic                      req_valid,
	output logic                           req_stall,
	input  wire logic [1:0]                kind,
	input  wire logic [gst_pkg::IDX_W-1:0] slot_index,
	input  wire logic [gst_pkg::VER_W-1:0] slot_version,
	input  wire logic [gst_pkg::PAY_W-1:0] payload,
	// response channel
	output logic                           rsp_valid,
	input  wire logic                      rsp_stall,
	output logic [1:0]                     status,
	output logic [gst_pkg::IDX_W-1:0]      out_index,
	output logic [gst_pkg::VER_W-1:0]      out_version,
	output logic [gst_pkg::PAY_W-1:0]      out_payload,
	output logic [gst_pkg::CNT_W-1:0]      trimmed
);

	localparam int IW = gst_pkg::IDX_W;
	localparam int CW = gst_pkg::CNT_W;
	localparam int VW = gst_pkg::VER_W;
	localparam int PW = gst_pkg::PAY_W;

	// Sequencer and counters
	gst_pkg::gst_state_t state_q, state_d;
	logic [CW-1:0] used_q, used_d;       // slots in use (table length)
	logic [CW-1:0] depth_q, depth_d;     // free stack depth
	logic [CW-1:0] trim_q, trim_d;       // slots trimmed by current compact
	logic [CW-1:0] search_q, search_d;   // next free stack entry to read
	logic          cmp_vld_s1, cmp_vld_d;
	logic          rsp_valid_q, rsp_valid_d;

	// Item and working registers
	logic [IW-1:0] idx_q;
	logic [VW-1:0] ver_q;
	logic [PW-1:0] pay_q;
	logic [IW-1:0] slot_q, slot_d;
	logic [IW-1:0] match_q, match_d;
	logic [IW-1:0] cmp_idx_s1, cmp_idx_d;
	logic          latch_in;
	logic          out_load;

	// Result being built, then handed to the output register
	logic [1:0]    res_status_q, res_status_d;
	logic [IW-1:0] res_index_q, res_index_d;
	logic [VW-1:0] res_version_q, res_version_d;
	logic [PW-1:0] res_payload_q, res_payload_d;
	logic [CW-1:0] res_trim_q, res_trim_d;

	logic [1:0]    status_q;
	logic [IW-1:0] out_index_q;
	logic [VW-1:0] out_version_q;
	logic [PW-1:0] out_payload_q;
	logic [CW-1:0] trimmed_q;

	// RAM ports
	logic          pay_we, ver_we, stk_we;
	logic [IW-1:0] pay_waddr, pay_raddr, ver_waddr, ver_raddr, stk_waddr, stk_raddr;
	logic [PW-1:0] pay_wdata, pay_rdata;
	logic [VW-1:0] ver_wdata, ver_rdata;
	logic [IW-1:0] stk_wdata, stk_rdata;

	logic [CW-1:0] used_m1;
	logic [CW-1:0] depth_m1;
	logic          idx_in_range;

	assign used_m1      = used_q - CW'(1);
	assign depth_m1     = depth_q - CW'(1);
	assign idx_in_range = {1'b0, idx_q} < used_q;

	// Slot payloads, slot versions and the free stack each live in one RAM.
	gst_ram #(.WIDTH(PW), .DEPTH(gst_pkg::SLOTS)) u_pay_ram (
		.clk   (clk),
		.we    (pay_we),
		.waddr (pay_waddr),
		.wdata (pay_wdata),
		.raddr (pay_raddr),
		.rdata (pay_rdata)
	);

	gst_ram #(.WIDTH(VW), .DEPTH(gst_pkg::SLOTS)) u_ver_ram (
		.clk   (clk),
		.we    (ver_we),
		.waddr (ver_waddr),
		.wdata (ver_wdata),
		.raddr (ver_raddr),
		.rdata (ver_rdata)
	);

	gst_ram #(.WIDTH(IW), .DEPTH(gst_pkg::SLOTS)) u_stk_ram (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	// Next state, RAM control and working values. Every write lands before
	// any later read of the same RAM is issued, so no forwarding is
	// needed: the sequencer itself is the interlock.
	always_comb begin
		state_d       = state_q;
		used_d        = used_q;
		depth_d       = depth_q;
		trim_d        = trim_q;
		search_d      = search_q;
		cmp_vld_d     = 1'b0;
		cmp_idx_d     = cmp_idx_s1;
		match_d       = match_q;
		slot_d        = slot_q;
		latch_in      = 1'b0;
		out_load      = 1'b0;
		res_status_d  = res_status_q;
		res_index_d   = res_index_q;
		res_version_d = res_version_q;
		res_payload_d = res_payload_q;
		res_trim_d    = res_trim_q;

		pay_we    = 1'b0;
		pay_waddr = idx_q;
		pay_wdata = '0;
		pay_raddr = idx_q;
		ver_we    = 1'b0;
		ver_waddr = idx_q;
		ver_wdata = '0;
		ver_raddr = idx_q;
		stk_we    = 1'b0;
		stk_waddr = depth_q[IW-1:0];
		stk_wdata = idx_q;
		stk_raddr = depth_m1[IW-1:0];

		case (state_q)
			gst_pkg::S_IDLE: begin
				if (req_valid) begin
					latch_in = 1'b1;
					case (kind)
						gst_pkg::KIND_INSERT: begin
							if (depth_q != '0) begin
								// reuse the most recently freed slot
								stk_raddr = depth_m1[IW-1:0];
								state_d   = gst_pkg::S_INS_POP;
							end else if (used_q < gst_pkg::SLOT_CNT) begin
								// append a fresh slot with version zero
								pay_we        = 1'b1;
								pay_waddr     = used_q[IW-1:0];
								pay_wdata     = payload;
								ver_we        = 1'b1;
								ver_waddr     = used_q[IW-1:0];
								ver_wdata     = '0;
								used_d        = used_q + CW'(1);
								res_status_d  = gst_pkg::STATUS_OK;
								res_index_d   = used_q[IW-1:0];
								res_version_d = '0;
								res_payload_d = '0;
								res_trim_d    = '0;
								state_d       = gst_pkg::S_FIN;
							end else begin
								res_status_d  = gst_pkg::STATUS_FULL;
								res_index_d   = '0;
								res_version_d = '0;
								res_payload_d = '0;
								res_trim_d    = '0;
								state_d       = gst_pkg::S_FIN;
							end
						end
						gst_pkg::KIND_GET: begin
							pay_raddr = slot_index;
							ver_raddr = slot_index;
							state_d   = gst_pkg::S_GET_CHK;
						end
						gst_pkg::KIND_REMOVE: begin
							pay_raddr = slot_index;
							ver_raddr = slot_index;
							state_d   = gst_pkg::S_REM_CHK;
						end
						gst_pkg::KIND_COMPACT: begin
							trim_d  = '0;
							state_d = gst_pkg::S_CP_RD;
						end
						default: begin
							state_d = gst_pkg::S_IDLE;
						end
					endcase
				end
			end

			gst_pkg::S_GET_CHK: begin
				res_index_d   = '0;
				res_version_d = '0;
				res_trim_d    = '0;
				if (idx_in_range && ver_rdata == ver_q) begin
					res_status_d  = gst_pkg::STATUS_OK;
					res_payload_d = pay_rdata;
				end else begin
					res_status_d  = gst_pkg::STATUS_INVALID;
					res_payload_d = '0;
				end
				state_d = gst_pkg::S_FIN;
			end

			gst_pkg::S_REM_CHK: begin
				res_index_d   = '0;
				res_version_d = '0;
				res_payload_d = '0;
				res_trim_d    = '0;
				if (!idx_in_range || ver_rdata != ver_q ||
						(pay_rdata == '0 && ver_q != '0)) begin
					res_status_d = gst_pkg::STATUS_INVALID;
				end else if (depth_q >= gst_pkg::SLOT_CNT) begin
					res_status_d = gst_pkg::STATUS_FULL;
				end else begin
					// clear the slot, bump its version and push it
					pay_we       = 1'b1;
					pay_waddr    = idx_q;
					pay_wdata    = '0;
					ver_we       = 1'b1;
					ver_waddr    = idx_q;
					ver_wdata    = ver_q + VW'(1);
					stk_we       = 1'b1;
					stk_waddr    = depth_q[IW-1:0];
					stk_wdata    = idx_q;
					depth_d      = depth_q + CW'(1);
					res_status_d = gst_pkg::STATUS_OK;
				end
				state_d = gst_pkg::S_FIN;
			end

			gst_pkg::S_INS_POP: begin
				// popped index arrives; store payload, fetch its version
				pay_we    = 1'b1;
				pay_waddr = stk_rdata;
				pay_wdata = pay_q;
				ver_raddr = stk_rdata;
				slot_d    = stk_rdata;
				depth_d   = depth_m1;
				state_d   = gst_pkg::S_INS_VER;
			end

			gst_pkg::S_INS_VER: begin
				res_status_d  = gst_pkg::STATUS_OK;
				res_index_d   = slot_q;
				res_version_d = ver_rdata;
				res_payload_d = '0;
				res_trim_d    = '0;
				state_d       = gst_pkg::S_FIN;
			end

			gst_pkg::S_CP_RD: begin
				if (used_q == '0) begin
					res_status_d  = gst_pkg::STATUS_OK;
					res_index_d   = '0;
					res_version_d = '0;
					res_payload_d = '0;
					res_trim_d    = trim_q;
					state_d       = gst_pkg::S_FIN;
				end else begin
					pay_raddr = used_m1[IW-1:0];
					state_d   = gst_pkg::S_CP_CHK;
				end
			end

			gst_pkg::S_CP_CHK: begin
				if (pay_rdata != '0) begin
					// last slot is live: stop trimming
					res_status_d  = gst_pkg::STATUS_OK;
					res_index_d   = '0;
					res_version_d = '0;
					res_payload_d = '0;
					res_trim_d    = trim_q;
					state_d       = gst_pkg::S_FIN;
				end else begin
					search_d = '0;
					state_d  = gst_pkg::S_CP_SRCH;
				end
			end

			gst_pkg::S_CP_SRCH: begin
				// one stack read per cycle, compared in the following cycle;
				// the first match from the bottom wins
				if (cmp_vld_s1 && stk_rdata == used_m1[IW-1:0]) begin
					match_d = cmp_idx_s1;
					state_d = gst_pkg::S_CP_SWRD;
				end else if (search_q < depth_q) begin
					stk_raddr = search_q[IW-1:0];
					cmp_idx_d = search_q[IW-1:0];
					cmp_vld_d = 1'b1;
					search_d  = search_q + CW'(1);
				end else if (!cmp_vld_s1) begin
					// slot not on the stack: just drop it
					used_d  = used_m1;
					trim_d  = trim_q + CW'(1);
					state_d = gst_pkg::S_CP_RD;
				end
			end

			gst_pkg::S_CP_SWRD: begin
				stk_raddr = depth_m1[IW-1:0];
				state_d   = gst_pkg::S_CP_SWWR;
			end

			gst_pkg::S_CP_SWWR: begin
				// move the top entry into the matched hole, pop, drop the slot
				stk_we    = 1'b1;
				stk_waddr = match_q;
				stk_wdata = stk_rdata;
				depth_d   = depth_m1;
				used_d    = used_m1;
				trim_d    = trim_q + CW'(1);
				state_d   = gst_pkg::S_CP_RD;
			end

			gst_pkg::S_FIN: begin
				if (!rsp_valid_q || !rsp_stall) begin
					out_load = 1'b1;
					state_d  = gst_pkg::S_IDLE;
				end
			end

			default: begin
				state_d = gst_pkg::S_IDLE;
			end
		endcase

		if (out_load) begin
			rsp_valid_d = 1'b1;
		end else if (rsp_stall) begin
			rsp_valid_d = rsp_valid_q;
		end else begin
			rsp_valid_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= gst_pkg::S_IDLE;
			used_q      <= '0;
			depth_q     <= '0;
			trim_q      <= '0;
			search_q    <= '0;
			cmp_vld_s1  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			used_q      <= used_d;
			depth_q     <= depth_d;
			trim_q      <= trim_d;
			search_q    <= search_d;
			cmp_vld_s1  <= cmp_vld_d;
			rsp_valid_q <= rsp_valid_d;
		end
	end

	// Payload registers: no reset needed.
	always_ff @(posedge clk) begin
		if (latch_in) begin
			idx_q <= slot_index;
			ver_q <= slot_version;
			pay_q <= payload;
		end
		slot_q        <= slot_d;
		match_q       <= match_d;
		cmp_idx_s1    <= cmp_idx_d;
		res_status_q  <= res_status_d;
		res_index_q   <= res_index_d;
		res_version_q <= res_version_d;
		res_payload_q <= res_payload_d;
		res_trim_q    <= res_trim_d;
		if (out_load) begin
			status_q      <= res_status_q;
			out_index_q   <= res_index_q;
			out_version_q <= res_version_q;
			out_payload_q <= res_payload_q;
			trimmed_q     <= res_trim_q;
		end
	end

	assign req_stall   = (state_q != gst_pkg::S_IDLE);
	assign rsp_valid   = rsp_valid_q;
	assign status      = status_q;
	assign out_index   = out_index_q;
	assign out_version = out_version_q;
	assign out_payload = out_payload_q;
	assign trimmed     = trimmed_q;

	// An accepted item always takes the sequencer out of idle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> (state_q != gst_pkg::S_IDLE))
		else $error("item accepted but sequencer stayed idle");

	// A pop only happens with a non-empty free stack.
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == gst_pkg::S_INS_POP) |-> (depth_q != '0))
		else $error("pop from an empty free stack");

	// Unlinking a slot shrinks both the table and the stack by one.
	a_unlink_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == gst_pkg::S_CP_SWWR) |=>
			(used_q == $past(used_m1) && depth_q == $past(depth_m1)))
		else $error("compact unlink did not shrink table and stack");

	// Counts stay within the table size.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(used_q <= gst_pkg::SLOT_CNT) && (depth_q <= gst_pkg::SLOT_CNT))
		else $error("slot or free stack count out of range");

endmodule

`default_nettype wire
